[hw/rtl/jsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsl_pkg
// Shared widths, codes and types for the jump search lower-bound block.
// ----------------------------------------------------------------------------
package jsl_pkg;

   localparam int DEFAULT_DEPTH     = 1024;
   localparam int DEFAULT_KEY_WIDTH = 32;

   localparam int LEN_W       = 11;
   localparam int SLOT_W      = 10;
   localparam int KEY_IN_W    = 32;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 32;
   localparam int ROOT_W      = 6;
   localparam int ROOT_CNT_W  = 3;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_ARRAY_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_JUMP_BLOCK   = 1'd1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_result_type;

endpackage

[hw/rtl/jump_search_lower_bound.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jump_search_lower_bound
// Sorted signed key store with jump search and in-block binary lower bound.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   tvalid/tready      tuser: operation; tdata: slot, key
//  rsp      out  tvalid/tready      tuser: found; tdata: match_index,
//                                   insert_pos, step_used
//  csr      in   csr_wr_en          csr_index, csr_wdata
//
//  A key write is taken in S_IDLE. A search runs the square root first when
//  jump_block is 0, then one S_JUMP read per block jumped, then S_BIN_START
//  and S_BIN per binary-search step, set by the single read port of the key
//  memory. A miss past the last key skips the equality read; a search of an
//  empty store goes straight to S_DONE.
//  Reset clears control state and both registers; the key memory is not
//  cleared. A stalled result holds the next search in its final state.
// ----------------------------------------------------------------------------
module jump_search_lower_bound #(
   parameter int DEPTH     = jsl_pkg::DEFAULT_DEPTH,
   parameter int KEY_WIDTH = jsl_pkg::DEFAULT_KEY_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] slot, [41:10] key, [47:42] zero
   input  logic [jsl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [9:0] match_index, [20:10] insert_pos, [31:21] step_used
   output logic [jsl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] found
   output logic                              rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [jsl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [jsl_pkg::LEN_W-1:0]         csr_wdata
);
   import jsl_pkg::*;

   localparam int AW = $clog2(DEPTH);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SQRT      = 3'd1;
   localparam logic [2:0] S_JUMP_INIT = 3'd2;
   localparam logic [2:0] S_JUMP      = 3'd3;
   localparam logic [2:0] S_BIN_START = 3'd4;
   localparam logic [2:0] S_BIN       = 3'd5;
   localparam logic [2:0] S_EQ        = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   logic [LEN_W-1:0]     array_length_ff, jump_block_ff;
   logic [2:0]           state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     step_ff, step_in;
   logic [LEN_W-1:0]     lo_ff, lo_in;
   logic [LEN_W-1:0]     hi_ff, hi_in;
   logic [LEN_W-1:0]     mid_ff, mid_in;
   logic [LEN_W-1:0]     ip_ff, ip_in;
   logic                 found_ff, found_in;
   logic [KEY_WIDTH-1:0] target_ff, target_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]    rsp_match_ff, rsp_match_in;
   logic [LEN_W-1:0]     rsp_ip_ff, rsp_ip_in;
   logic [LEN_W-1:0]     rsp_step_ff, rsp_step_in;

   logic [KEY_WIDTH-1:0] mem [DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic                 rd_en;
   logic [LEN_W-1:0]     rd_idx;
   logic                 wr_en;

   logic [SLOT_W-1:0]    req_slot;
   logic [KEY_IN_W-1:0]  req_key;
   logic [KEY_WIDTH-1:0] req_key_w;
   logic [LEN_W-1:0]     len_cfg;
   logic [LEN_W-1:0]     hi_first;
   logic [LEN_W:0]       hi_sum;
   logic [LEN_W-1:0]     hi_next;
   logic [LEN_W-1:0]     mid_calc;
   logic                 key_less;

   logic                 sqrt_start;
   sqrt_result_type      sqrt_res;

   jsl_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (len_cfg),
      .result   (sqrt_res)
   );

   always_comb begin
      req_slot  = req_tdata[SLOT_W-1:0];
      req_key   = req_tdata[SLOT_W +: KEY_IN_W];
      req_key_w = KEY_WIDTH'(64'(req_key));
      len_cfg   = (32'(array_length_ff) > DEPTH) ? LEN_W'(DEPTH) : array_length_ff;
      hi_first  = (step_ff < len_ff) ? step_ff : len_ff;
      hi_sum    = {1'b0, hi_ff} + {1'b0, step_ff};
      hi_next   = (hi_sum < {1'b0, len_ff}) ? hi_sum[LEN_W-1:0] : len_ff;
      mid_calc  = lo_ff + ((hi_ff - lo_ff) >> 1);
      key_less  = $signed(rd_data_ff) < $signed(target_ff);
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      ip_in        = ip_ff;
      found_in     = found_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_match_in = rsp_match_ff;
      rsp_ip_in    = rsp_ip_ff;
      rsp_step_in  = rsp_step_ff;
      rd_en        = 1'b0;
      rd_idx       = '0;
      wr_en        = 1'b0;
      sqrt_start   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_WRITE) begin
                  wr_en = (32'(req_slot) < DEPTH);
               end else if (req_tuser == OP_SEARCH) begin
                  target_in = req_key_w;
                  len_in    = len_cfg;
                  lo_in     = '0;
                  ip_in     = '0;
                  found_in  = 1'b0;
                  if (len_cfg == '0) begin
                     step_in  = '0;
                     state_in = S_DONE;
                  end else if (jump_block_ff == '0) begin
                     sqrt_start = 1'b1;
                     state_in   = S_SQRT;
                  end else begin
                     step_in  = jump_block_ff;
                     state_in = S_JUMP_INIT;
                  end
               end
            end
         end
         S_SQRT: begin
            if (sqrt_res.done) begin
               step_in  = LEN_W'(sqrt_res.root);
               state_in = S_JUMP_INIT;
            end
         end
         S_JUMP_INIT: begin
            lo_in = '0;
            hi_in = hi_first;
            if (hi_first < len_ff) begin
               rd_en    = 1'b1;
               rd_idx   = hi_first - 1'b1;
               state_in = S_JUMP;
            end else begin
               state_in = S_BIN_START;
            end
         end
         S_JUMP: begin
            // rd_data holds the last key of the current block
            if (key_less) begin
               lo_in = hi_ff;
               hi_in = hi_next;
               if (hi_next < len_ff) begin
                  rd_en  = 1'b1;
                  rd_idx = hi_next - 1'b1;
               end else begin
                  state_in = S_BIN_START;
               end
            end else begin
               state_in = S_BIN_START;
            end
         end
         S_BIN_START: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_idx   = mid_calc;
               mid_in   = mid_calc;
               state_in = S_BIN;
            end else begin
               ip_in = lo_ff;
               if (lo_ff < len_ff) begin
                  rd_en    = 1'b1;
                  rd_idx   = lo_ff;
                  state_in = S_EQ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_BIN: begin
            if (key_less) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_BIN_START;
         end
         S_EQ: begin
            found_in = (rd_data_ff == target_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_match_in = found_ff ? ip_ff[SLOT_W-1:0] : '0;
               rsp_ip_in    = ip_ff;
               rsp_step_in  = step_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_slot)] <= req_key_w;
      end
      if (rd_en) begin
         rd_data_ff <= mem[AW'(rd_idx)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         array_length_ff <= '0;
         jump_block_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ARRAY_LENGTH: array_length_ff <= csr_wdata;
            REG_JUMP_BLOCK:   jump_block_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff       <= len_in;
      step_ff      <= step_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      ip_ff        <= ip_in;
      found_ff     <= found_in;
      target_ff    <= target_in;
      rsp_found_ff <= rsp_found_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ip_ff    <= rsp_ip_in;
      rsp_step_ff  <= rsp_step_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {rsp_step_ff, rsp_ip_ff, rsp_match_ff};

   a_match_is_ip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_match_ff == rsp_ip_ff[SLOT_W-1:0])
      else $error("match index differs from insertion point");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_match_ff == '0)
      else $error("match index nonzero on a miss");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JUMP || state_ff == S_BIN_START || state_ff == S_BIN)
      |-> lo_ff <= hi_ff && hi_ff <= len_ff)
      else $error("search window out of order");

   a_sqrt_when_waiting: assert property (@(posedge clock) disable iff (reset)
      sqrt_res.done |-> state_ff == S_SQRT)
      else $error("square root finished outside its wait state");

endmodule

[hw/rtl/jsl_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsl_sqrt
// Floor square root of the store length, one result bit per cycle.
// ----------------------------------------------------------------------------
module jsl_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [jsl_pkg::LEN_W-1:0]    radicand,
   output jsl_pkg::sqrt_result_type     result
);
   import jsl_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_CNT_W-1:0] bit_ff, bit_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [LEN_W-1:0]      n_ff, n_in;
   logic [ROOT_W-1:0]     trial;
   logic [2*ROOT_W-1:0]   square;

   always_comb begin
      trial  = root_ff | (ROOT_W'(1) << bit_ff);
      square = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      root_in = root_ff;
      n_in    = n_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = ROOT_CNT_W'(ROOT_W - 1);
         root_in = '0;
         n_in    = radicand;
      end else if (busy_ff) begin
         if (square <= (2*ROOT_W)'(n_ff)) begin
            root_in = trial;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff  <= bit_in;
      root_ff <= root_in;
      n_ff    <= n_in;
   end

   assign result.done = done_ff;
   assign result.root = root_ff;

endmodule

[test/tb_jump_search_lower_bound.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jump_search_lower_bound
// Self-checking bench for the sorted key store with jump search.
// Keys are loaded as sorted runs with random content and searched with targets
// drawn from the loaded keys, their neighbors, random values and the signed
// extremes. Each accepted item also goes to a scoreboard that keeps its own key
// store and registers, predicts every search result and compares it field by
// field. Both sides pause at random; the receiver also holds off once for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_jump_search_lower_bound;
   import jsl_pkg::*;

   localparam int STORE_DEPTH = 1024;

   typedef struct packed {
      logic        found;
      logic [9:0]  match_index;
      logic [10:0] insert_pos;
      logic [10:0] step_used;
   } bound_result_t;

   class lower_bound_board;
      logic signed [31:0] key_mirror [STORE_DEPTH];
      logic [10:0]        length_reg;
      logic [10:0]        jump_reg;
      bound_result_t      pending_bounds [$];
      int                 errors;
      int                 checked;

      function new();
         length_reg = '0;
         jump_reg   = '0;
         errors     = 0;
         checked    = 0;
      endfunction

      function void set_config(logic [10:0] length_value, logic [10:0] jump_value);
         length_reg = length_value;
         jump_reg   = jump_value;
      endfunction

      function int pending();
         return pending_bounds.size();
      endfunction

      function bound_result_t jump_lower_bound(logic signed [31:0] target);
         bound_result_t r;
         int len, step, lo, hi, mid, nx;
         r   = '0;
         len = (length_reg > STORE_DEPTH) ? STORE_DEPTH : int'(length_reg);
         if (len == 0) return r;
         if (jump_reg != 0) begin
            step = int'(jump_reg);
         end else begin
            step = 0;
            while ((step + 1) * (step + 1) <= len) step++;
         end
         if (step < 1) step = 1;
         lo = 0;
         hi = (step < len) ? step : len;
         while (hi < len && key_mirror[hi-1] < target) begin
            nx = hi + step;
            lo = hi;
            hi = (nx < len) ? nx : len;
         end
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_mirror[mid] < target) lo = mid + 1;
            else hi = mid;
         end
         if (lo < len && key_mirror[lo] == target) begin
            r.found       = 1'b1;
            r.match_index = lo[9:0];
         end
         r.insert_pos = lo[10:0];
         r.step_used  = step[10:0];
         return r;
      endfunction

      function void note_request(logic op, logic [9:0] slot, logic [31:0] key);
         if (op == OP_WRITE) key_mirror[slot] = key;
         else pending_bounds.push_back(jump_lower_bound(key));
      endfunction

      function void compare(string field, int expected, int actual);
         if (expected != actual) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, expected, actual);
         end
      endfunction

      function void check_result(logic found, logic [RSP_DATA_W-1:0] data);
         bound_result_t want;
         checked++;
         if (pending_bounds.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual found=%0d data=%h",
                     $time, found, data);
            return;
         end
         want = pending_bounds.pop_front();
         compare("found", want.found, found);
         compare("match_index", want.match_index, data[9:0]);
         compare("insert_pos", want.insert_pos, data[20:10]);
         compare("step_used", want.step_used, data[31:21]);
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_wr_en  = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [LEN_W-1:0]        csr_wdata  = '0;

   lower_bound_board board;
   bit               no_idle = 1'b0;

   jump_search_lower_bound dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(input logic op, input logic [9:0] slot, input logic [31:0] key);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, key, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, slot, key);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_config(input logic [10:0] len, input logic [10:0] jb);
      csr_wr_en <= 1'b1;
      csr_index <= REG_ARRAY_LENGTH;
      csr_wdata <= len;
      @(posedge clock);
      csr_index <= REG_JUMP_BLOCK;
      csr_wdata <= jb;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_config(len, jb);
   endtask

   // refill loads slots below the length with a fresh ascending run
   task automatic run_phase(input int len, input int jb, input int n_ops, input bit refill);
      int          span, cnt, idx, step_max;
      longint      v;
      logic [31:0] target;
      logic [9:0]  slot_pick;
      settle();
      set_config(len[10:0], jb[10:0]);
      no_idle = ($urandom_range(0, 3) == 0);
      span = (len > STORE_DEPTH) ? STORE_DEPTH : len;
      if (refill) begin
         case ($urandom_range(0, 2))
            0: step_max = 3;
            1: step_max = 2000;
            default: step_max = 4000000;
         endcase
         if ($urandom_range(0, 4) == 0) v = -64'sd2147483648;
         else v = longint'($signed($urandom));
         for (int i = 0; i < span; i++) begin
            send_item(OP_WRITE, i[9:0], v[31:0]);
            v = v + longint'($urandom_range(0, step_max));
            if (v > 64'sd2147483647) v = 64'sd2147483647;
         end
      end
      for (cnt = 0; cnt < n_ops; cnt++) begin
         slot_pick = $urandom_range(0, STORE_DEPTH - 1);
         if ($urandom_range(0, 5) == 0) begin
            send_item(OP_WRITE, slot_pick, $urandom);
         end else begin
            case ($urandom_range(0, 7))
               0: target = $urandom;
               1: target = 32'h8000_0000;
               2: target = 32'h7fff_ffff;
               default: begin
                  if (span > 0) begin
                     idx    = $urandom_range(0, span - 1);
                     target = board.key_mirror[idx] + 32'($urandom_range(0, 2)) - 32'd1;
                  end else begin
                     target = $urandom;
                  end
               end
            endcase
            send_item(OP_SEARCH, slot_pick, target);
         end
      end
   endtask

   initial begin : result_side
      int gap;
      bit held;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!held && board.checked >= 60) begin
            gap  = 300;
            held = 1'b1;
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_result(rsp_tuser, rsp_tdata);
      end
   end

   initial begin : timeout
      #10_000_000;
      $display("tb_jump_search_lower_bound: FAIL");
      $finish;
   end

   initial begin : stimulus
      int len, jb;
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero length after reset
      send_item(OP_SEARCH, 10'h3ff, 32'h8000_0000);
      send_item(OP_SEARCH, 10'h000, 32'h7fff_ffff);

      // ascending keys with duplicates and both signed extremes
      send_item(OP_WRITE, 10'd0, 32'h8000_0000);
      send_item(OP_WRITE, 10'd1, -32'sd5);
      send_item(OP_WRITE, 10'd2, -32'sd5);
      send_item(OP_WRITE, 10'd3, 32'd0);
      send_item(OP_WRITE, 10'd4, 32'd7);
      send_item(OP_WRITE, 10'd5, 32'd7);
      send_item(OP_WRITE, 10'd6, 32'd7);
      send_item(OP_WRITE, 10'd7, 32'h7fff_ffff);
      send_item(OP_WRITE, 10'h3ff, 32'h5a5a_a5a5);
      settle();
      set_config(11'd8, 11'd0);
      send_item(OP_SEARCH, 10'd0, 32'h8000_0000);
      send_item(OP_SEARCH, 10'd0, 32'h7fff_ffff);
      send_item(OP_SEARCH, 10'd0, -32'sd6);
      send_item(OP_SEARCH, 10'd0, -32'sd5);
      send_item(OP_SEARCH, 10'd0, 32'd7);
      send_item(OP_SEARCH, 10'd0, 32'd8);
      send_item(OP_SEARCH, 10'd0, 32'd0);
      send_item(OP_SEARCH, 10'd0, 32'd6);
      // step larger than the length, then step of one
      settle();
      set_config(11'd8, 11'h7ff);
      send_item(OP_SEARCH, 10'd0, 32'd7);
      send_item(OP_SEARCH, 10'd0, 32'h7fff_ffff);
      settle();
      set_config(11'd8, 11'd1);
      send_item(OP_SEARCH, 10'd0, 32'd7);
      settle();
      set_config(11'd0, 11'd3);
      send_item(OP_SEARCH, 10'd0, 32'd5);

      repeat (7) begin
         case ($urandom_range(0, 5))
            0: len = 1;
            1: len = 2;
            2: len = $urandom_range(3, 16);
            3, 4: len = $urandom_range(17, 48);
            default: len = $urandom_range(49, 150);
         endcase
         case ($urandom_range(0, 5))
            0, 1, 2: jb = 0;
            3: jb = $urandom_range(1, len + 3);
            4: jb = 1;
            default: jb = ($urandom_range(0, 1) == 0) ? 2047 : 1024;
         endcase
         run_phase(len, jb, 20, 1'b1);
      end

      // whole and saturated length: the smallest target visits at most the
      // last key of the first block and the halving points below it
      settle();
      send_item(OP_WRITE, 10'd0, 32'h8000_0000);
      send_item(OP_WRITE, 10'd31, 32'h8000_0000);
      for (int i = 1; i <= 512; i = i * 2) begin
         send_item(OP_WRITE, i[9:0], 32'h8000_0000);
      end
      settle();
      set_config(11'd1024, 11'd0);
      send_item(OP_SEARCH, 10'd0, 32'h8000_0000);
      settle();
      set_config(11'd2047, 11'd0);
      send_item(OP_SEARCH, 10'd0, 32'h8000_0000);
      settle();
      set_config(11'd2047, 11'd33);
      send_item(OP_SEARCH, 10'd0, 32'h8000_0000);
      settle();
      set_config(11'd2047, 11'h7ff);
      send_item(OP_SEARCH, 10'd0, 32'h8000_0000);
      settle();
      set_config(11'd1024, 11'd1024);
      send_item(OP_SEARCH, 10'd0, 32'h8000_0000);
      run_phase(0, 0, 3, 1'b0);

      settle();
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb_jump_search_lower_bound: PASS");
      end else begin
         $display("tb_jump_search_lower_bound: FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/jsl_pkg.sv
hw/rtl/jsl_sqrt.sv
hw/rtl/jump_search_lower_bound.sv
test/tb_jump_search_lower_bound.sv
